[sv/tgrs_pkg.sv]
// Shared constants and the normal-CDF table for the Gaussian row smoother.
// No dependencies; every other file but tgrs_div refers to it by scoped names.
`default_nettype none
package tgrs_pkg;

    localparam int MAX_REACH_DEF        = 24;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int VAL_W                = 32;
    localparam int SIGMA_W              = 12;
    localparam int ARG_W                = 10;
    localparam int ROM_LAST             = 24;

    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 12'd256;
    localparam logic [ARG_W-1:0]   ARG_MAX     = 10'd768;
    localparam logic [2:0]         ADDR_SIGMA  = 3'd0;

    // Area of the unit normal from 0 to idx/8 sigma, Q0.16.
    function automatic logic [15:0] cdf_rom(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:  v = 16'd0;
            5'd1:  v = 16'd3260;
            5'd2:  v = 16'd6469;
            5'd3:  v = 16'd9579;
            5'd4:  v = 16'd12548;
            5'd5:  v = 16'd15336;
            5'd6:  v = 16'd17916;
            5'd7:  v = 16'd20265;
            5'd8:  v = 16'd22370;
            5'd9:  v = 16'd24229;
            5'd10: v = 16'd25844;
            5'd11: v = 16'd27226;
            5'd12: v = 16'd28390;
            5'd13: v = 16'd29355;
            5'd14: v = 16'd30143;
            5'd15: v = 16'd30776;
            5'd16: v = 16'd31277;
            5'd17: v = 16'd31668;
            5'd18: v = 16'd31967;
            5'd19: v = 16'd32193;
            5'd20: v = 16'd32361;
            5'd21: v = 16'd32484;
            5'd22: v = 16'd32573;
            5'd23: v = 16'd32636;
            5'd24: v = 16'd32679;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[sv/tgrs_if.sv]
// Valid/ready channel interfaces for bin items and smoothed items.
// Depends on tgrs_pkg for the value width.
`default_nettype none
interface tgrs_in_if;
    logic                       valid;
    logic                       ready;
    logic [tgrs_pkg::VAL_W-1:0] bin_value;
    logic                       last_bin;
    modport source (output valid, output bin_value, output last_bin, input ready);
    modport sink (input valid, input bin_value, input last_bin, output ready);
endinterface

interface tgrs_out_if;
    logic                       valid;
    logic                       ready;
    logic [tgrs_pkg::VAL_W-1:0] smoothed_value;
    logic                       last_out;
    modport source (output valid, output smoothed_value, output last_out, input ready);
    modport sink (input valid, input smoothed_value, input last_out, output ready);
endinterface
`default_nettype wire

[sv/tgrs_cell.sv]
// One window cell: holds a bin, forms its weighted product and adds it to the
// running sums passed from its neighbor. Depends on tgrs_pkg.
`default_nettype none
module tgrs_cell #(
    parameter int IDX    = 0,
    parameter int R      = 24,
    parameter int WB     = 17,
    parameter int ACC_W  = 55,
    parameter int WSUM_W = 23
) (
    input  logic                             i_clk,
    input  logic                             i_shift,
    input  logic [tgrs_pkg::VAL_W-1:0]       i_sample,
    output logic [tgrs_pkg::VAL_W-1:0]       o_sample,
    input  logic [R:0][WB-1:0]               i_taps,
    input  logic [$clog2(R+1)-1:0]           i_center,
    input  logic [$clog2(2*R+2)-1:0]         i_count,
    input  logic [ACC_W-1:0]                 i_acc,
    input  logic [WSUM_W-1:0]                i_wsum,
    output logic [ACC_W-1:0]                 o_acc,
    output logic [WSUM_W-1:0]                o_wsum
);
    localparam int WIN   = 2 * R + 1;
    localparam int KW    = $clog2(WIN);
    localparam int CW    = $clog2(R + 1);
    localparam int CNT_W = $clog2(WIN + 1);
    localparam int PW    = WB + tgrs_pkg::VAL_W;

    logic [tgrs_pkg::VAL_W-1:0] r_sample;
    logic [PW-1:0]              r_prod;
    logic [WB-1:0]              r_w;
    logic [ACC_W-1:0]           r_acc;
    logic [WSUM_W-1:0]          r_wsum;
    logic [KW-1:0]              pos;
    logic [KW-1:0]              ctr;
    logic [KW-1:0]              tap_dist;
    logic                       use_tap;
    logic [WB-1:0]              w;

    always_comb begin
        pos      = KW'(IDX);
        ctr      = KW'(i_center);
        tap_dist = (pos >= ctr) ? pos - ctr : ctr - pos;
        use_tap  = (CNT_W'(IDX) < i_count) && (tap_dist <= KW'(R));
        w        = use_tap ? i_taps[tap_dist[CW-1:0]] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
        r_w    <= w;
        r_prod <= use_tap ? w * r_sample : '0;
        r_acc  <= i_acc + ACC_W'(r_prod);
        r_wsum <= i_wsum + WSUM_W'(r_w);
    end

    assign o_sample = r_sample;
    assign o_acc    = r_acc;
    assign o_wsum   = r_wsum;
endmodule
`default_nettype wire

[sv/tgrs_div.sv]
// Restoring divider, one quotient bit per cycle, shared by tap and result work.
// No dependencies.
`default_nettype none
module tgrs_div #(
    parameter int DW = 56,
    parameter int VW = 23
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_dvs;
    logic [VW:0]   rem_sh;
    logic          ge;
    logic [VW:0]   n_rem;

    always_comb begin
        rem_sh = {r_rem[VW-1:0], r_quo[DW-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        n_rem  = ge ? rem_sh - {1'b0, r_dvs} : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

[sv/truncated_gaussian_row_smoother_unit.sv]
// Gaussian row smoother: chain of 2*MAX_REACH+1 cells, shared divider, APB sigma.
// Depends on tgrs_pkg, tgrs_if, tgrs_cell and tgrs_div.
// An item with no result is taken straight from idle unless it opens a row. For each
// result the sums ripple through the cell chain, the divider is started and, once its
// quotient is done, the result is emitted. The first item of a row adds MAX_REACH+1 tap
// divisions. Reset clears control state and sets sigma to 1.0 bin; the window is masked
// by the bin count.
`default_nettype none
module truncated_gaussian_row_smoother_unit #(
    parameter int MAX_REACH        = tgrs_pkg::MAX_REACH_DEF,
    parameter int WEIGHT_FRAC_BITS = tgrs_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tgrs_in_if.sink     i_in,
    tgrs_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int R      = MAX_REACH;
    localparam int WFB    = WEIGHT_FRAC_BITS;
    localparam int WIN    = 2 * R + 1;
    localparam int WB     = WFB + 1;
    localparam int CW     = $clog2(R + 1);
    localparam int CNT_W  = $clog2(WIN + 1);
    localparam int ACC_W  = WB + tgrs_pkg::VAL_W + $clog2(WIN);
    localparam int WSUM_W = WB + $clog2(WIN);
    localparam int DIV_DW = ACC_W + 1;
    localparam int WT_W   = $clog2(WIN + 2);
    localparam int VAL_W  = tgrs_pkg::VAL_W;
    localparam int SW     = tgrs_pkg::SIGMA_W;
    localparam int AW     = tgrs_pkg::ARG_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_TAP_GO   = 3'd1;
    localparam logic [2:0] S_TAP_WAIT = 3'd2;
    localparam logic [2:0] S_SETTLE   = 3'd3;
    localparam logic [2:0] S_DIV_WAIT = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    logic [2:0]           r_state;
    logic [SW-1:0]        r_sigma;
    logic [CNT_W-1:0]     r_seen;
    logic [CNT_W-1:0]     r_n;
    logic                 r_last;
    logic                 r_any;
    logic [CW-1:0]        r_c;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_j;
    logic [R:0][WB-1:0]   r_taps;
    logic [WFB-1:0]       r_prev;
    logic [WT_W-1:0]      r_wait;
    logic [VAL_W-1:0]     r_res;
    logic                 r_ov;
    logic [VAL_W-1:0]     r_oval;
    logic                 r_olast;

    logic                 acc_in;
    logic                 cfg_wr;
    logic [CNT_W-1:0]     n_cnt;
    logic [CW-1:0]        n_hi;
    logic                 n_any;
    logic                 out_free;

    logic [VAL_W-1:0]     sample_link [WIN+1];
    logic [ACC_W-1:0]     acc_link    [WIN+1];
    logic [WSUM_W-1:0]    wsum_link   [WIN+1];

    logic                 div_start;
    logic [DIV_DW-1:0]    div_num;
    logic [WSUM_W-1:0]    div_den;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_DW-1:0]    div_q;

    logic [SW-1:0]        sig_eff;
    logic [AW-1:0]        arg;
    logic [4:0]           ridx;
    logic [4:0]           rfr;
    logic [15:0]          rom_lo;
    logic [15:0]          rom_hi;
    logic [20:0]          interp;
    logic [15:0]          g;
    logic [16+WFB-1:0]    g_ext;
    logic [WFB-1:0]       g_s;
    logic [WB-1:0]        n_tap;
    logic [VAL_W-1:0]     n_res;

    assign pready   = 1'b1;
    assign prdata   = (paddr == tgrs_pkg::ADDR_SIGMA) ? 32'(r_sigma) : '0;
    assign cfg_wr   = psel && penable && pwrite && (paddr == tgrs_pkg::ADDR_SIGMA);
    assign i_in.ready = (r_state == S_IDLE);
    assign acc_in   = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_ov || o_out.ready;

    assign o_out.valid          = r_ov;
    assign o_out.smoothed_value = r_oval;
    assign o_out.last_out       = r_olast;

    always_comb begin
        n_cnt = (r_seen == CNT_W'(WIN)) ? r_seen : r_seen + 1'b1;
        n_hi  = (n_cnt > CNT_W'(R)) ? CW'(R) : CW'(n_cnt - 1'b1);
        n_any = i_in.last_bin || (n_cnt > CNT_W'(R));
    end

    // Cell chain.
    assign sample_link[0] = i_in.bin_value;
    assign acc_link[0]    = '0;
    assign wsum_link[0]   = '0;

    for (genvar k = 0; k < WIN; k++) begin : g_cell
        tgrs_cell #(
            .IDX(k), .R(R), .WB(WB), .ACC_W(ACC_W), .WSUM_W(WSUM_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_shift  (acc_in),
            .i_sample (sample_link[k]),
            .o_sample (sample_link[k+1]),
            .i_taps   (r_taps),
            .i_center (r_c),
            .i_count  (r_n),
            .i_acc    (acc_link[k]),
            .i_wsum   (wsum_link[k]),
            .o_acc    (acc_link[k+1]),
            .o_wsum   (wsum_link[k+1])
        );
    end

    // Tap weight from the divider quotient.
    always_comb begin
        sig_eff = (r_sigma == '0) ? SW'(1) : r_sigma;
        arg     = (div_q > DIV_DW'(tgrs_pkg::ARG_MAX)) ? tgrs_pkg::ARG_MAX : AW'(div_q);
        ridx    = arg[AW-1:5];
        rfr     = arg[4:0];
        rom_lo  = tgrs_pkg::cdf_rom(ridx);
        rom_hi  = tgrs_pkg::cdf_rom(ridx + 5'd1);
        interp  = 21'((rom_hi - rom_lo) * rfr) + 21'd16;
        g       = (ridx < 5'(tgrs_pkg::ROM_LAST)) ? rom_lo + interp[20:5] : rom_lo;
        g_ext   = {g, {WFB{1'b0}}};
        g_s     = g_ext[16+WFB-1:16];
        n_tap   = (r_j == '0) ? {g_s, 1'b0} : WB'(g_s - r_prev);
        n_res   = (wsum_link[WIN] == '0) ? '0
                : ((div_q >> VAL_W) != '0) ? '1 : div_q[VAL_W-1:0];
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = DIV_DW'({r_j, 1'b1, 15'd0}) + DIV_DW'(sig_eff[SW-1:1]);
        div_den   = WSUM_W'(sig_eff);
        if (r_state == S_TAP_GO) begin
            div_start = 1'b1;
        end else if (r_state == S_SETTLE) begin
            div_start = (r_wait == WT_W'(WIN + 1));
            div_num   = DIV_DW'(acc_link[WIN]) + DIV_DW'(wsum_link[WIN] >> 1);
            div_den   = wsum_link[WIN];
        end
    end

    tgrs_div #(.DW(DIV_DW), .VW(WSUM_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sigma <= tgrs_pkg::SIGMA_RESET;
            r_seen  <= '0;
            r_n     <= '0;
            r_last  <= 1'b0;
            r_any   <= 1'b0;
            r_c     <= '0;
            r_lo    <= '0;
            r_j     <= '0;
            r_wait  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_sigma <= pwdata[SW-1:0];
            end
            if (o_out.ready && !(r_state == S_EMIT && out_free)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_n    <= n_cnt;
                        r_seen <= i_in.last_bin ? '0 : n_cnt;
                        r_last <= i_in.last_bin;
                        r_any  <= n_any;
                        r_c    <= n_hi;
                        r_lo   <= i_in.last_bin ? '0 : CW'(R);
                        r_j    <= '0;
                        r_wait <= '0;
                        if (r_seen == '0) begin
                            r_state <= S_TAP_GO;
                        end else if (n_any) begin
                            r_state <= S_SETTLE;
                        end
                    end
                end
                S_TAP_GO: begin
                    r_state <= S_TAP_WAIT;
                end
                S_TAP_WAIT: begin
                    if (div_done) begin
                        if (r_j == CW'(R)) begin
                            r_state <= r_any ? S_SETTLE : S_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_TAP_GO;
                        end
                    end
                end
                S_SETTLE: begin
                    r_wait <= r_wait + 1'b1;
                    if (div_start) begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov   <= 1'b1;
                        r_wait <= '0;
                        if (r_c == r_lo) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_c     <= r_c - 1'b1;
                            r_state <= S_SETTLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_TAP_WAIT && div_done) begin
            r_taps[r_j] <= n_tap;
            r_prev      <= g_s;
        end
        if (r_state == S_DIV_WAIT && div_done) begin
            r_res <= n_res;
        end
        if (r_state == S_EMIT && out_free) begin
            r_oval  <= r_res;
            r_olast <= r_last && (r_c == '0);
        end
    end

    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= CNT_W'(WIN))
        else $error("bin count beyond window");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && i_in.last_bin) |=> (r_seen == '0))
        else $error("row end did not clear bin count");

    a_center_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETTLE) |-> (r_c >= r_lo))
        else $error("center below lowest output");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking bench for the truncated Gaussian row smoother: random rows, APB sigma writes,
// an in-bench model of the tap weights and edge renormalization, random stalls on both sides.
// Depends on tgrs_pkg, tgrs_if and truncated_gaussian_row_smoother_unit.
`timescale 1ns / 100ps
module tb_top;

    localparam int REACH    = tgrs_pkg::MAX_REACH_DEF;
    localparam int SPAN     = 2 * REACH + 1;
    localparam int WD_LIMIT = 40000;

    typedef struct {
        logic [tgrs_pkg::VAL_W-1:0] value;
        logic                       last;
    } t_bin_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    tgrs_in_if  bin_if ();
    tgrs_out_if sm_if ();

    truncated_gaussian_row_smoother_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(bin_if), .o_out(sm_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    t_bin_item bin_q[$];
    t_bin_item smoothed_q[$];
    bit gaps_on = 1'b1;
    int errors = 0, bins_sent = 0, results_seen = 0, rows_sent = 0, sigma_writes = 0;
    int idle_left = 0, stall_left = 0, quiet_cycles = 0;

    // Model state
    logic [tgrs_pkg::SIGMA_W-1:0] sigma_q = tgrs_pkg::SIGMA_RESET;
    logic [31:0] window_q[SPAN];
    logic [31:0] weight_q[REACH+1];
    int row_count = 0;

    localparam logic [15:0] CDF[25] = '{
        16'd0, 16'd3260, 16'd6469, 16'd9579, 16'd12548, 16'd15336, 16'd17916, 16'd20265,
        16'd22370, 16'd24229, 16'd25844, 16'd27226, 16'd28390, 16'd29355, 16'd30143,
        16'd30776, 16'd31277, 16'd31668, 16'd31967, 16'd32193, 16'd32361, 16'd32484,
        16'd32573, 16'd32636, 16'd32679};

    function automatic logic [31:0] area_to(input int m, input int s);
        int t, idx, fr;
        logic [31:0] g;
        t = (m * 32768 + s / 2) / s;
        if (t > 768) t = 768;
        idx = t >> 5;
        fr = t & 31;
        g = CDF[idx];
        if (idx < 24) g += ((CDF[idx+1] - CDF[idx]) * fr + 16) >> 5;
        return 32'((64'(g) << tgrs_pkg::WEIGHT_FRAC_BITS_DEF) >> 16);
    endfunction

    function automatic void derive_weights();
        int s;
        logic [31:0] prev, cur;
        s = (sigma_q == 0) ? 1 : int'(sigma_q);
        prev = area_to(1, s);
        weight_q[0] = 2 * prev;
        for (int d = 1; d <= REACH; d++) begin
            cur = area_to(2 * d + 1, s);
            weight_q[d] = cur - prev;
            prev = cur;
        end
    endfunction

    function automatic logic [31:0] smoothed_at(input int c, input int avail);
        logic [63:0] acc, wsum, q;
        int k;
        acc = 0;
        wsum = 0;
        for (int d = -REACH; d <= REACH; d++) begin
            k = c + d;
            if (k >= 0 && k < avail) begin
                acc += 64'(weight_q[d < 0 ? -d : d]) * window_q[k];
                wsum += weight_q[d < 0 ? -d : d];
            end
        end
        if (wsum == 0) return 0;
        q = (acc + wsum / 2) / wsum;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic void smooth_bin(input t_bin_item it);
        int hi, lo;
        t_bin_item r;
        if (row_count == 0) derive_weights();
        for (int k = SPAN - 1; k > 0; k--) window_q[k] = window_q[k-1];
        window_q[0] = it.value;
        if (row_count < SPAN) row_count++;
        hi = (row_count > REACH) ? REACH : row_count - 1;
        lo = it.last ? 0 : REACH;
        for (int c = hi; c >= lo; c--) begin
            r.value = smoothed_at(c, row_count);
            r.last = it.last && c == 0;
            smoothed_q.push_back(r);
        end
        if (it.last) row_count = 0;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("tb_top: mismatch: %s", msg);
    endtask

    // Bin driver
    always @(posedge i_clk) begin : bin_driver
        t_bin_item nxt;
        if (!i_rst_n) begin
            bin_if.valid <= 1'b0;
            bin_if.bin_value <= '0;
            bin_if.last_bin <= 1'b0;
        end else begin
            if (bin_if.valid && bin_if.ready) begin
                nxt.value = bin_if.bin_value;
                nxt.last = bin_if.last_bin;
                smooth_bin(nxt);
                bins_sent++;
                if (nxt.last) rows_sent++;
            end
            if (!bin_if.valid || bin_if.ready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    bin_if.valid <= 1'b0;
                end else if (bin_q.size() > 0) begin
                    nxt = bin_q.pop_front();
                    bin_if.valid <= 1'b1;
                    bin_if.bin_value <= nxt.value;
                    bin_if.last_bin <= nxt.last;
                    if (gaps_on && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 18);
                end else begin
                    bin_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : result_monitor
        t_bin_item want;
        if (!i_rst_n) begin
            sm_if.ready <= 1'b0;
        end else begin
            if (sm_if.valid && sm_if.ready) begin
                results_seen++;
                if (smoothed_q.size() == 0) begin
                    flag_error($sformatf("unexpected item value %h last %b",
                                         sm_if.smoothed_value, sm_if.last_out));
                end else begin
                    want = smoothed_q.pop_front();
                    if (sm_if.smoothed_value !== want.value)
                        flag_error($sformatf("smoothed_value exp %h got %h",
                                             want.value, sm_if.smoothed_value));
                    if (sm_if.last_out !== want.last)
                        flag_error($sformatf("last_out exp %b got %b",
                                             want.last, sm_if.last_out));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                sm_if.ready <= 1'b0;
            end else begin
                sm_if.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 18);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if ((bin_if.valid && bin_if.ready) || (sm_if.valid && sm_if.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("tb_top: watchdog expired, %0d items pending", smoothed_q.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_sigma(input logic [tgrs_pkg::SIGMA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= tgrs_pkg::ADDR_SIGMA;
        pwdata <= {20'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sigma_q = val;
        sigma_writes++;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata[tgrs_pkg::SIGMA_W-1:0] !== val)
            flag_error($sformatf("sigma readback exp %h got %h", val,
                                 prdata[tgrs_pkg::SIGMA_W-1:0]));
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_bin(input logic [31:0] v, input logic last);
        t_bin_item it;
        it.value = v;
        it.last = last;
        bin_q.push_back(it);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (bin_q.size() > 0 || bin_if.valid || smoothed_q.size() > 0);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [tgrs_pkg::SIGMA_W-1:0] pick_sigma();
        case ($urandom_range(0, 7))
            0: return 12'd16;
            1: return 12'd2048;
            2: return 12'd4095;
            3: return 12'd0;
            default: return $urandom_range(16, 2048);
        endcase
    endfunction

    initial begin : stimulus
        int len, random_bins;
        random_bins = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default sigma: field extremes, single-bin row
        push_bin(32'h0, 1'b0);
        push_bin(32'hFFFF_FFFF, 1'b0);
        push_bin(32'h1, 1'b1);
        push_bin(32'hFFFF_FFFF, 1'b1);
        drain();
        write_sigma(12'd16);
        push_bin(32'h8000_0000, 1'b0);
        push_bin(32'h7FFF_FFFF, 1'b0);
        push_bin(32'h5555_5555, 1'b0);
        push_bin(32'hAAAA_AAAA, 1'b0);
        push_bin(32'h0001_0000, 1'b1);
        drain();
        write_sigma(12'd0);
        push_bin(32'hFFFF_FFFF, 1'b0);
        push_bin(32'h0000_FFFF, 1'b1);
        drain();
        // Wide sigma, changed mid-row
        write_sigma(12'd4095);
        for (int k = 0; k < 10; k++) push_bin(32'hFFFF_FFFF, 1'b0);
        drain();
        repeat (1700) @(posedge i_clk);
        write_sigma(12'd2048);
        for (int k = 0; k < 5; k++) push_bin(pick_value(), k == 4);
        drain();

        while (random_bins < 90) begin
            if (random_bins >= 65) gaps_on = 1'b0;
            write_sigma(pick_sigma());
            repeat ($urandom_range(1, 2)) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(49, 60)
                                                  : $urandom_range(1, 30);
                for (int k = 0; k < len; k++) push_bin(pick_value(), k == len - 1);
                random_bins += len;
            end
            drain();
        end

        repeat (300) @(posedge i_clk);
        $display("tb_top: %0d bins in %0d rows, %0d smoothed items checked",
                 bins_sent, rows_sent, results_seen);
        $display("tb_top: %0d sigma writes incl. 0, 16, 2048, 4095 and a mid-row change",
                 sigma_writes);
        if (errors == 0 && smoothed_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
